/* hdl/dwr_pkg.sv */
package dwr_pkg;

  localparam int unsigned DEPTH    = 256;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DIV_N_W  = $clog2(WORD_W + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DRAW    = 3'd0,
    FUNC_REMOVE  = 3'd1,
    FUNC_APPEND  = 3'd2,
    FUNC_RESTART = 3'd3,
    FUNC_REFILL  = 3'd4,
    FUNC_SEQ     = 3'd5
  } dwr_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EXHAUSTED   = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_EMPTY_RANGE = 3'd4
  } dwr_status_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } dwr_mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } dwr_mod_rsp_t;

endpackage

/* hdl/dwr_if.sv */
interface dwr_in_if;
  import dwr_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] random_word;
  logic [WORD_W-1:0] value;
  modport source (output valid, func, random_word, value, input ready);
  modport sink (input valid, func, random_word, value, output ready);
endinterface

interface dwr_out_if;
  import dwr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   drawn_value;
  logic [CNT_W-1:0]    remaining;
  modport source (output valid, status, drawn_value, remaining, input ready);
  modport sink (input valid, status, drawn_value, remaining, output ready);
endinterface

/* hdl/dwr_ram.sv */
module dwr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/dwr_mod.sv */
module dwr_mod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dwr_pkg::dwr_mod_req_t req_i,
  output dwr_pkg::dwr_mod_rsp_t rsp_o
);
  import dwr_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIV_N_W-1:0]  n_q, n_d;
  logic [WORD_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    div_q, div_d;
  logic [CNT_W:0]      trial;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    n_d    = n_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[WORD_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      n_d    = DIV_N_W'(WORD_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[CNT_W-1:0];
      n_d   = n_q - DIV_N_W'(1);
      if (n_q == DIV_N_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      n_q    <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[IDX_W-1:0];

endmodule

/* hdl/draw_without_replacement_pool_core.sv */
// Ordered pool of 16-bit values for drawing without replacement.
// Input channel in_i carries one command word (func, random_word, value); output
// channel out_o returns one result word (status, drawn_value, remaining) per command.
// Words move when valid and ready are both high. The user writes registers pool_low
// (0x0) and pool_high (0x4) over the APB port only while idle; the block does not enforce it.
// The pool lives in one 256 x 16 RAM with registered read data; a result register
// parts the two channels, so a held result does not stop the next command from being
// taken, though only one command is worked on at a time.
// Steps from accept to result valid, receiver ready:
//   append, sequential, failed draw, empty range, unused codes: straight to the result
//   draw: the remainder unit picks the index, the entry is read, then the tail shifts down
//   remove: scan up to the match, then shift the tail; when absent, scan to the end
//   restart, refill: one RAM write a cycle for each loaded entry
// The next command is taken in the cycle after the previous result is loaded, so
// a command is never taken before the previous one has reached the result register.
// Reset clears count, top, flags and registers; the RAM is not cleared, and no entry
// beyond the count is ever used. When the receiver stalls, the result is held and a
// finished command waits for the result register before it is released.
module draw_without_replacement_pool_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dwr_in_if.sink      in_i,
  dwr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dwr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIV      = 8'b0000_0010,
    S_DRAW_RD  = 8'b0000_0100,
    S_DRAW_CAP = 8'b0000_1000,
    S_SHIFT    = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_FILL     = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;

  // Registers and architectural state.
  logic [WORD_W-1:0] pool_low_q, pool_high_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] top_q, top_d;
  logic              exh_q, exh_d;
  logic [WORD_W-1:0] last_q, last_d;

  // Captured command word and walk pointers.
  logic [FUNC_W-1:0] func_q, func_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              pend_q, pend_d;

  // Pending result and output register.
  dwr_status_e       res_st_q, res_st_d;
  logic [WORD_W-1:0] res_val_q, res_val_d;
  logic              out_vld_q, out_vld_d;
  logic [STATUS_W-1:0] out_st_q;
  logic [WORD_W-1:0] out_val_q;
  logic [CNT_W-1:0]  out_rem_q;
  logic              out_load;

  // RAM port.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  dwr_mod_req_t      mod_req;
  dwr_mod_rsp_t      mod_rsp;

  logic              accept;
  logic [WORD_W-1:0] load_hi;
  logic [WORD_W:0]   span;
  logic [WORD_W:0]   seq_nx;
  logic [CNT_W-1:0]  ptr_m2;
  logic [WORD_W-1:0] fill_val;

  // APB: writes land at the access phase, reads decode on paddr[2].
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'd0, pool_high_q} : {16'd0, pool_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_low_q  <= '0;
      pool_high_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        pool_high_q <= pwdata[WORD_W-1:0];
      end else begin
        pool_low_q <= pwdata[WORD_W-1:0];
      end
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign load_hi  = (in_i.func == FUNC_RESTART) ? pool_high_q : top_q;
  assign span     = {1'b0, load_hi} - {1'b0, pool_low_q};
  assign seq_nx   = {1'b0, last_q} + (WORD_W + 1)'(1);
  assign ptr_m2   = ptr_q - CNT_W'(2);
  assign fill_val = pool_low_q + WORD_W'(ptr_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    exh_d     = exh_q;
    last_d    = last_q;
    func_d    = func_q;
    val_d     = val_q;
    ptr_d     = ptr_q;
    pend_d    = pend_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[IDX_W-1:0];
    ram_wdata = fill_val;
    ram_raddr = ptr_q[IDX_W-1:0];
    mod_req.start    = 1'b0;
    mod_req.dividend = in_i.random_word;
    mod_req.divisor  = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d    = in_i.func;
          val_d     = in_i.value;
          res_st_d  = ST_OK;
          res_val_d = '0;
          ptr_d     = '0;
          pend_d    = 1'b0;
          state_d   = S_RESP;
          case (in_i.func)
            FUNC_DRAW: begin
              if (exh_q || cnt_q == '0) begin
                res_st_d = ST_EXHAUSTED;
              end else begin
                mod_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            FUNC_REMOVE: begin
              state_d = S_SCAN;
            end
            FUNC_APPEND: begin
              if (cnt_q == CNT_W'(DEPTH) || top_q == '1) begin
                res_st_d = ST_FULL;
              end else begin
                // Append top+1 at the tail.
                ram_we    = 1'b1;
                ram_waddr = cnt_q[IDX_W-1:0];
                ram_wdata = top_q + WORD_W'(1);
                top_d     = top_q + WORD_W'(1);
                cnt_d     = cnt_q + CNT_W'(1);
                exh_d     = 1'b0;
              end
            end
            FUNC_RESTART, FUNC_REFILL: begin
              top_d  = load_hi;
              last_d = '0;
              exh_d  = 1'b0;
              if (load_hi < pool_low_q) begin
                cnt_d    = '0;
                exh_d    = 1'b1;
                res_st_d = ST_EMPTY_RANGE;
              end else begin
                if (span >= (WORD_W + 1)'(DEPTH)) begin
                  cnt_d    = CNT_W'(DEPTH);
                  res_st_d = (span == (WORD_W + 1)'(DEPTH - 1)) ? ST_OK : ST_FULL;
                end else begin
                  cnt_d = span[CNT_W-1:0] + CNT_W'(1);
                end
                state_d = S_FILL;
              end
            end
            FUNC_SEQ: begin
              if (top_q < pool_low_q) begin
                res_st_d = ST_EMPTY_RANGE;
              end else if (seq_nx > {1'b0, top_q}) begin
                last_d    = pool_low_q;
                res_val_d = pool_low_q;
              end else begin
                last_d    = seq_nx[WORD_W-1:0];
                res_val_d = seq_nx[WORD_W-1:0];
              end
            end
            default: begin
              res_st_d = ST_OK;
            end
          endcase
        end
      end

      S_DIV: begin
        if (mod_rsp.done) begin
          ptr_d   = {1'b0, mod_rsp.rem};
          state_d = S_DRAW_RD;
        end
      end

      S_DRAW_RD: begin
        state_d = S_DRAW_CAP;
      end

      S_DRAW_CAP: begin
        res_val_d = ram_rdata;
        ptr_d     = ptr_q + CNT_W'(1);
        pend_d    = 1'b0;
        state_d   = S_SHIFT;
      end

      S_SHIFT: begin
        // Read entry ptr while writing the previous read one slot lower.
        ram_we    = pend_q;
        ram_waddr = ptr_m2[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (ptr_q < cnt_q) begin
          ptr_d  = ptr_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          cnt_d  = cnt_q - CNT_W'(1);
          if (func_q == FUNC_DRAW && cnt_q == CNT_W'(1)) begin
            exh_d = 1'b1;
          end
          res_st_d = ST_OK;
          state_d  = S_RESP;
        end
      end

      S_SCAN: begin
        if (pend_q && ram_rdata == val_q) begin
          // First match sits at ptr-1: shift from ptr.
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end else if (ptr_q < cnt_q) begin
          ptr_d  = ptr_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d   = 1'b0;
          res_st_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end
      end

      S_FILL: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + CNT_W'(1);
        if (ptr_q == cnt_q - CNT_W'(1)) begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        // Release once the output register is free.
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      top_q     <= '0;
      exh_q     <= 1'b0;
      last_q    <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      top_q     <= top_d;
      exh_q     <= exh_d;
      last_q    <= last_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    val_q     <= val_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    if (out_load) begin
      out_st_q  <= res_st_q;
      out_val_q <= res_val_q;
      out_rem_q <= cnt_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_st_q;
  assign out_o.drawn_value = out_val_q;
  assign out_o.remaining   = out_rem_q;

  dwr_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  dwr_ram #(
    .Width (WORD_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
